@@ rtl/sfod_pkg.sv @@
package sfod_pkg;

    localparam int DEF_MAX_BAND_BINS  = 64;
    localparam int DEF_RING_DEPTH     = 43;
    localparam int DEF_DIVISION_COUNT = 5;

    localparam int MAG_W       = 16;
    localparam int FLUX_W      = 22;
    localparam int LEVEL_W     = 16;
    localparam int SENS_W      = 15;
    localparam int SENS_FRAC   = 12;
    localparam int REFR_W      = 8;
    localparam int GATE_W      = 15;
    localparam int DECAY_W     = 16;
    localparam int ENV_W       = 16;
    localparam int HOPS_W      = 12;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [FLUX_W-1:0]  FLUX_MAX    = '1;
    localparam logic [SENS_W-1:0]  SENS_MIN    = 15'd4096;
    localparam logic [SENS_W-1:0]  SENS_MAX    = 15'd16384;
    localparam logic [SENS_W-1:0]  SENS_RESET  = 15'd6554;
    localparam logic [REFR_W-1:0]  REFR_RESET  = 8'd20;
    localparam logic [GATE_W-1:0]  GATE_MAX    = 15'd16384;
    localparam logic [GATE_W-1:0]  GATE_RESET  = 15'd0;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64153;
    // epsilon 1e-5 in Q0.28
    localparam int unsigned        EPS_Q28     = 2684;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SENSITIVITY = 2'd0,
        REG_REFRACTORY  = 2'd1,
        REG_NOISE_GATE  = 2'd2,
        REG_ENV_DECAY   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SENS_W-1:0]  sensitivity;
        logic [REFR_W-1:0]  refractory_hops;
        logic [GATE_W-1:0]  noise_gate;
        logic [DECAY_W-1:0] env_decay;
    } cfg_t;

    typedef struct packed {
        logic [FLUX_W-1:0]  flux;
        logic [LEVEL_W-1:0] raw_level;
        logic               material_gate;
    } hop_t;

    typedef struct packed {
        logic [FLUX_W-1:0]  flux;
        logic [FLUX_W-1:0]  mean;
        logic [LEVEL_W-1:0] raw_level;
        logic               material_gate;
    } hop_stat_t;

endpackage

@@ rtl/spectral_flux_onset_detector.sv @@
// Spectral-flux onset detector for one band. Magnitude bins stream in one per
// clock while bin_ready is high; a result beat comes out for each bin flagged
// last_bin, and bins that do not end a hop produce nothing. Sustained rate is
// one bin per cycle unless stalled, set by the previous-frame memory, which
// does one read-modify-write per bin with forwarding when consecutive bins hit
// the same entry. Hops may follow each other every cycle unless stalled; the
// flux ring is a second memory with its next entry prefetched. Both memories
// start logically zero through a fill mark, so there is no clearing pass after
// reset. Configuration writes take effect at once and belong in idle periods.
module spectral_flux_onset_detector #(
    parameter int MAX_BAND_BINS  = sfod_pkg::DEF_MAX_BAND_BINS,
    parameter int RING_DEPTH     = sfod_pkg::DEF_RING_DEPTH,
    parameter int DIVISION_COUNT = sfod_pkg::DEF_DIVISION_COUNT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [sfod_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfod_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             bin_valid,
    output logic                             bin_ready,
    input  logic [sfod_pkg::MAG_W-1:0]       magnitude,
    input  logic                             last_bin,
    input  logic [sfod_pkg::LEVEL_W-1:0]     raw_level,
    input  logic                             material_gate,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             fired,
    output logic [sfod_pkg::FLUX_W-1:0]      flux_value,
    output logic [sfod_pkg::FLUX_W-1:0]      flux_mean,
    output logic                             refractory_blocked,
    output logic [sfod_pkg::ENV_W-1:0]       envelope,
    output logic [DIVISION_COUNT-1:0]        division_toggles,
    output logic [sfod_pkg::COUNT_W-1:0]     onset_total
);
    import sfod_pkg::*;

    cfg_t              cfg_reg;
    logic [SENS_W-1:0] sens_raw;
    logic [SENS_W-1:0] sens_clamped;
    logic [GATE_W-1:0] gate_raw;
    logic [GATE_W-1:0] gate_clamped;

    logic              hop_valid;
    logic              hop_ready;
    hop_t              hop;
    logic              stat_valid;
    logic              stat_ready;
    hop_stat_t         stat;

    always_comb
    begin
        sens_raw = cfg_data[SENS_W-1:0];
        gate_raw = cfg_data[GATE_W-1:0];
        if (sens_raw < SENS_MIN)
        begin
            sens_clamped = SENS_MIN;
        end
        else if (sens_raw > SENS_MAX)
        begin
            sens_clamped = SENS_MAX;
        end
        else
        begin
            sens_clamped = sens_raw;
        end
        gate_clamped = (gate_raw > GATE_MAX) ? GATE_MAX : gate_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensitivity     <= SENS_RESET;
            cfg_reg.refractory_hops <= REFR_RESET;
            cfg_reg.noise_gate      <= GATE_RESET;
            cfg_reg.env_decay       <= DECAY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SENSITIVITY: cfg_reg.sensitivity     <= sens_clamped;
                REG_REFRACTORY:  cfg_reg.refractory_hops <= cfg_data[REFR_W-1:0];
                REG_NOISE_GATE:  cfg_reg.noise_gate      <= gate_clamped;
                REG_ENV_DECAY:   cfg_reg.env_decay       <= cfg_data[DECAY_W-1:0];
            endcase
        end
    end

    sfod_bin_stage #(
        .MAX_BAND_BINS (MAX_BAND_BINS)
    ) u_bin_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .bin_valid     (bin_valid),
        .bin_ready     (bin_ready),
        .magnitude     (magnitude),
        .last_bin      (last_bin),
        .raw_level     (raw_level),
        .material_gate (material_gate),
        .hop_valid     (hop_valid),
        .hop_ready     (hop_ready),
        .hop           (hop)
    );

    sfod_flux_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_flux_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .hop_valid  (hop_valid),
        .hop_ready  (hop_ready),
        .hop        (hop),
        .stat_valid (stat_valid),
        .stat_ready (stat_ready),
        .stat       (stat)
    );

    sfod_fire_stage #(
        .DIVISION_COUNT (DIVISION_COUNT)
    ) u_fire_stage (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .stat_valid         (stat_valid),
        .stat_ready         (stat_ready),
        .stat               (stat),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .fired              (fired),
        .flux_value         (flux_value),
        .flux_mean          (flux_mean),
        .refractory_blocked (refractory_blocked),
        .envelope           (envelope),
        .division_toggles   (division_toggles),
        .onset_total        (onset_total)
    );

endmodule

@@ rtl/sfod_bin_stage.sv @@
module sfod_bin_stage #(
    parameter int MAX_BAND_BINS = sfod_pkg::DEF_MAX_BAND_BINS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         bin_valid,
    output logic                         bin_ready,
    input  logic [sfod_pkg::MAG_W-1:0]   magnitude,
    input  logic                         last_bin,
    input  logic [sfod_pkg::LEVEL_W-1:0] raw_level,
    input  logic                         material_gate,
    output logic                         hop_valid,
    input  logic                         hop_ready,
    output sfod_pkg::hop_t               hop
);
    import sfod_pkg::*;

    localparam int PosW  = (MAX_BAND_BINS > 1) ? $clog2(MAX_BAND_BINS) : 1;
    localparam int FillW = $clog2(MAX_BAND_BINS + 1);
    localparam logic [PosW-1:0] LastPos = PosW'(MAX_BAND_BINS - 1);

    logic [MAG_W-1:0]   frame_mem [MAX_BAND_BINS];

    logic [PosW-1:0]    pos_reg;
    logic [FillW-1:0]   fill_reg;
    logic [FLUX_W-1:0]  acc_reg;

    logic               s1_valid_reg;
    logic [PosW-1:0]    s1_pos_reg;
    logic [MAG_W-1:0]   s1_mag_reg;
    logic               s1_last_reg;
    logic [LEVEL_W-1:0] s1_raw_reg;
    logic               s1_gate_reg;
    logic [MAG_W-1:0]   rd_data_reg;
    logic               rd_known_reg;
    logic               fwd_reg;
    logic [MAG_W-1:0]   fwd_mag_reg;

    logic               hop_valid_reg;
    hop_t               hop_reg;

    logic               hop_free;
    logic               s1_leave;
    logic               accept;
    logic [MAG_W-1:0]   prev;
    logic [MAG_W-1:0]   rise;
    logic [FLUX_W:0]    acc_sum;
    logic [FLUX_W-1:0]  flux_sat;

    assign hop_free  = !hop_valid_reg || hop_ready;
    assign s1_leave  = s1_valid_reg && (!s1_last_reg || hop_free);
    assign bin_ready = !s1_valid_reg || s1_leave;
    assign accept    = bin_valid && bin_ready;

    always_comb
    begin
        if (fwd_reg)
        begin
            prev = fwd_mag_reg;
        end
        else if (rd_known_reg)
        begin
            prev = rd_data_reg;
        end
        else
        begin
            prev = '0;
        end
        rise     = (s1_mag_reg > prev) ? s1_mag_reg - prev : '0;
        acc_sum  = {1'b0, acc_reg} + (FLUX_W + 1)'(rise);
        flux_sat = acc_sum[FLUX_W] ? FLUX_MAX : acc_sum[FLUX_W-1:0];
    end

    // previous-frame store: read on accept, written back when the bin retires
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= frame_mem[pos_reg];
        end
        if (s1_leave)
        begin
            frame_mem[s1_pos_reg] <= s1_mag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= pos_reg;
            s1_mag_reg   <= magnitude;
            s1_last_reg  <= last_bin;
            s1_raw_reg   <= raw_level;
            s1_gate_reg  <= material_gate;
            rd_known_reg <= FillW'(pos_reg) < fill_reg;
            fwd_reg      <= s1_valid_reg && (s1_pos_reg == pos_reg);
            fwd_mag_reg  <= s1_mag_reg;
        end
        if (s1_leave && s1_last_reg)
        begin
            hop_reg.flux          <= flux_sat;
            hop_reg.raw_level     <= s1_raw_reg;
            hop_reg.material_gate <= s1_gate_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            acc_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            hop_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                if (last_bin)
                begin
                    pos_reg <= '0;
                end
                else if (pos_reg != LastPos)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            else if (s1_leave)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_leave)
            begin
                acc_reg <= s1_last_reg ? '0 : flux_sat;
                if (FillW'(s1_pos_reg) == fill_reg)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end

            if (s1_leave && s1_last_reg)
            begin
                hop_valid_reg <= 1'b1;
            end
            else if (hop_ready)
            begin
                hop_valid_reg <= 1'b0;
            end
        end
    end

    assign hop_valid = hop_valid_reg;
    assign hop       = hop_reg;

    // bins are written in order from position zero, so a held bin never skips past the fill mark
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (FillW'(s1_pos_reg) <= fill_reg))
        else $error("bin position beyond previous-frame fill mark");

endmodule

@@ rtl/sfod_flux_ring.sv @@
module sfod_flux_ring #(
    parameter int RING_DEPTH = sfod_pkg::DEF_RING_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hop_valid,
    output logic                hop_ready,
    input  sfod_pkg::hop_t      hop,
    output logic                stat_valid,
    input  logic                stat_ready,
    output sfod_pkg::hop_stat_t stat
);
    import sfod_pkg::*;

    localparam int SumW = FLUX_W + $clog2(RING_DEPTH);
    localparam int PtrW = $clog2(RING_DEPTH);
    localparam longint unsigned RecipL = (longint'(1) << SumW) / RING_DEPTH;
    localparam logic [SumW-1:0] Recip   = SumW'(RecipL);
    localparam logic [SumW-1:0] DepthS  = SumW'(RING_DEPTH);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

    logic [FLUX_W-1:0]  ring_mem [RING_DEPTH];
    logic [FLUX_W-1:0]  old_reg;
    logic [PtrW-1:0]    ptr_reg;
    logic [PtrW-1:0]    ptr_next;
    logic               wrapped_reg;
    logic [SumW-1:0]    sum_reg;

    logic               a_valid_reg;
    logic [2*SumW-1:0]  a_prod_reg;
    logic [SumW-1:0]    a_sum_reg;
    hop_t               a_hop_reg;

    logic               b_valid_reg;
    hop_stat_t          b_stat_reg;

    logic               b_free;
    logic               a_leave;
    logic               h_leave;
    logic [FLUX_W-1:0]  old_flux;
    logic [SumW-1:0]    q_est;
    logic [SumW-1:0]    q_times_d;
    logic [SumW-1:0]    rem;
    logic               corr;

    assign b_free    = !b_valid_reg || stat_ready;
    assign a_leave   = a_valid_reg && b_free;
    assign hop_ready = !a_valid_reg || b_free;
    assign h_leave   = hop_valid && hop_ready;

    assign old_flux = wrapped_reg ? old_reg : '0;

    always_comb
    begin
        if (h_leave)
        begin
            ptr_next = (ptr_reg == PtrLast) ? '0 : ptr_reg + 1'b1;
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    // floor(sum / depth): reciprocal estimate is low by at most one
    assign q_est     = a_prod_reg[2*SumW-1:SumW];
    assign q_times_d = q_est * DepthS;
    assign rem       = a_sum_reg - q_times_d;
    assign corr      = rem >= DepthS;

    // entry at the next pointer is prefetched so it is ready for the next hop
    always_ff @(posedge clk)
    begin
        old_reg <= ring_mem[ptr_next];
        if (h_leave)
        begin
            ring_mem[ptr_reg] <= hop.flux;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_leave)
        begin
            a_prod_reg <= {{SumW{1'b0}}, sum_reg} * {{SumW{1'b0}}, Recip};
            a_sum_reg  <= sum_reg;
            a_hop_reg  <= hop;
        end
        if (a_leave)
        begin
            b_stat_reg.flux          <= a_hop_reg.flux;
            b_stat_reg.mean          <= q_est[FLUX_W-1:0] + FLUX_W'(corr);
            b_stat_reg.raw_level     <= a_hop_reg.raw_level;
            b_stat_reg.material_gate <= a_hop_reg.material_gate;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (h_leave)
            begin
                sum_reg <= sum_reg - SumW'(old_flux) + SumW'(hop.flux);
                if (ptr_reg == PtrLast)
                begin
                    wrapped_reg <= 1'b1;
                end
            end

            if (h_leave)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_leave)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_leave)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (stat_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    assign stat_valid = b_valid_reg;
    assign stat       = b_stat_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PtrLast)
        else $error("flux ring pointer out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (rem < (DepthS << 1)))
        else $error("mean estimate off by more than one");

endmodule

@@ rtl/sfod_fire_stage.sv @@
module sfod_fire_stage #(
    parameter int DIVISION_COUNT = sfod_pkg::DEF_DIVISION_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfod_pkg::cfg_t               cfg,
    input  logic                         stat_valid,
    output logic                         stat_ready,
    input  sfod_pkg::hop_stat_t          stat,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         fired,
    output logic [sfod_pkg::FLUX_W-1:0]  flux_value,
    output logic [sfod_pkg::FLUX_W-1:0]  flux_mean,
    output logic                         refractory_blocked,
    output logic [sfod_pkg::ENV_W-1:0]   envelope,
    output logic [DIVISION_COUNT-1:0]    division_toggles,
    output logic [sfod_pkg::COUNT_W-1:0] onset_total
);
    import sfod_pkg::*;

    localparam int ThrW = FLUX_W + SENS_W + 1;

    logic                      t_valid_reg;
    logic [ThrW-1:0]           t_thr_reg;
    hop_stat_t                 t_stat_reg;

    logic [HOPS_W-1:0]         hops_reg;
    logic [ENV_W-1:0]          env_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [DIVISION_COUNT-1:0] toggle_reg;

    logic                      result_valid_reg;
    logic                      fired_reg;
    logic [FLUX_W-1:0]         flux_reg;
    logic [FLUX_W-1:0]         mean_reg;
    logic                      blocked_reg;

    logic                      out_free;
    logic                      t_leave;
    logic [HOPS_W-1:0]         hops_inc;
    logic                      blocked;
    logic                      above;
    logic                      fire;
    logic [COUNT_W-1:0]        count_inc;
    logic [DIVISION_COUNT-1:0] flip;
    logic [2*ENV_W-1:0]        env_prod;
    logic [ENV_W-1:0]          env_fire;

    assign out_free   = !result_valid_reg || result_ready;
    assign t_leave    = t_valid_reg && out_free;
    assign stat_ready = !t_valid_reg || out_free;

    always_comb
    begin
        hops_inc  = (hops_reg == '1) ? hops_reg : hops_reg + 1'b1;
        blocked   = hops_inc <= HOPS_W'(cfg.refractory_hops);
        above     = ThrW'({t_stat_reg.flux, {SENS_FRAC{1'b0}}}) > t_thr_reg;
        fire      = above && !blocked && t_stat_reg.material_gate
                    && (t_stat_reg.raw_level >= LEVEL_W'(cfg.noise_gate));
        count_inc = count_reg + 1'b1;
        flip      = '0;
        for (int d = 0; d < DIVISION_COUNT; d++)
        begin
            flip[d] = (count_inc & COUNT_W'((64'd1 << d) - 64'd1)) == '0;
        end
        env_prod = {{ENV_W{1'b0}}, env_reg} * {{(2*ENV_W-DECAY_W){1'b0}}, cfg.env_decay};
        // full scale times decay, shifted down
        env_fire = ENV_W'(cfg.env_decay >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (stat_valid && stat_ready)
        begin
            t_thr_reg  <= ThrW'(stat.mean) * ThrW'(cfg.sensitivity) + ThrW'(EPS_Q28);
            t_stat_reg <= stat;
        end
        if (t_leave)
        begin
            fired_reg   <= fire;
            flux_reg    <= t_stat_reg.flux;
            mean_reg    <= t_stat_reg.mean;
            blocked_reg <= blocked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            hops_reg         <= '1;
            env_reg          <= '0;
            count_reg        <= '0;
            toggle_reg       <= '0;
        end
        else
        begin
            if (stat_valid && stat_ready)
            begin
                t_valid_reg <= 1'b1;
            end
            else if (t_leave)
            begin
                t_valid_reg <= 1'b0;
            end

            if (t_leave)
            begin
                result_valid_reg <= 1'b1;
                hops_reg         <= fire ? '0 : hops_inc;
                env_reg          <= fire ? env_fire : env_prod[2*ENV_W-1:ENV_W];
                if (fire)
                begin
                    count_reg  <= count_inc;
                    toggle_reg <= toggle_reg ^ flip;
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid       = result_valid_reg;
    assign fired              = fired_reg;
    assign flux_value         = flux_reg;
    assign flux_mean          = mean_reg;
    assign refractory_blocked = blocked_reg;
    assign envelope           = env_reg;
    assign division_toggles   = toggle_reg;
    assign onset_total        = count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && fired_reg) |-> !blocked_reg)
        else $error("onset fired inside refractory window");

    assert property (@(posedge clk) disable iff (!rst_n)
        (t_leave && fire) |=> (hops_reg == '0 && count_reg == $past(count_inc)))
        else $error("fire did not restart hop count or bump onset total");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
    import sfod_pkg::*;

    localparam int MAX_BINS     = DEF_MAX_BAND_BINS;
    localparam int RING_LEN     = DEF_RING_DEPTH;
    localparam int DIVS         = DEF_DIVISION_COUNT;
    localparam int BIN_IDX_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int RING_IDX_W   = $clog2(RING_LEN);
    localparam int HOPS_SAT     = (1 << HOPS_W) - 1;
    localparam int ENV_FULL     = 32768;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef enum {HOP_QUIET, HOP_BURST, HOP_NOISE} hop_style_t;

    typedef struct {
        logic              fired;
        logic [FLUX_W-1:0] flux;
        logic [FLUX_W-1:0] mean;
        logic              blocked;
        logic [ENV_W-1:0]  env;
        logic [DIVS-1:0]   toggles;
        logic [COUNT_W-1:0] total;
    } hop_result_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SENSITIVITY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic bin_valid = 1'b0;
    logic bin_ready;
    logic [MAG_W-1:0] magnitude = '0;
    logic last_bin = 1'b0;
    logic [LEVEL_W-1:0] raw_level = '0;
    logic material_gate = 1'b0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic fired;
    logic [FLUX_W-1:0] flux_value;
    logic [FLUX_W-1:0] flux_mean;
    logic refractory_blocked;
    logic [ENV_W-1:0] envelope;
    logic [DIVS-1:0] division_toggles;
    logic [COUNT_W-1:0] onset_total;

    // detector state as predicted
    logic [MAG_W-1:0]      last_frame [MAX_BINS] = '{default: '0};
    logic [FLUX_W-1:0]     flux_hist [RING_LEN] = '{default: '0};
    logic [27:0]           hist_sum = '0;
    logic [RING_IDX_W-1:0] hist_ptr = '0;
    logic [BIN_IDX_W-1:0]  bin_idx = '0;
    logic [FLUX_W-1:0]     flux_sum = '0;
    logic [HOPS_W-1:0]     hops_since = HOPS_W'(HOPS_SAT);
    logic [ENV_W-1:0]      env_level = '0;
    logic [COUNT_W-1:0]    onset_count = '0;
    logic [DIVS-1:0]       div_bits = '0;
    logic [SENS_W-1:0]     sens_q = SENS_RESET;
    logic [REFR_W-1:0]     refr_hops = REFR_RESET;
    logic [GATE_W-1:0]     gate_level = GATE_RESET;
    logic [DECAY_W-1:0]    decay_q = DECAY_RESET;

    hop_result_t pending_hops [$];
    int mismatch_count = 0;
    int bins_sent = 0;
    int cycle_count = 0;
    logic idle_off = 1'b0;

    spectral_flux_onset_detector dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .bin_valid          (bin_valid),
        .bin_ready          (bin_ready),
        .magnitude          (magnitude),
        .last_bin           (last_bin),
        .raw_level          (raw_level),
        .material_gate      (material_gate),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .fired              (fired),
        .flux_value         (flux_value),
        .flux_mean          (flux_mean),
        .refractory_blocked (refractory_blocked),
        .envelope           (envelope),
        .division_toggles   (division_toggles),
        .onset_total        (onset_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic advance_detector(input logic [MAG_W-1:0] mag, input logic last,
                                    input logic [LEVEL_W-1:0] raw, input logic gate);
        logic [BIN_IDX_W-1:0] pos;
        longint unsigned acc;
        longint unsigned thr;
        logic [FLUX_W-1:0] mean;
        hop_result_t r;
        pos = bin_idx;
        if (mag > last_frame[pos])
        begin
            acc = longint'(flux_sum) + longint'(mag) - longint'(last_frame[pos]);
            flux_sum = (acc > FLUX_MAX) ? FLUX_MAX : acc[FLUX_W-1:0];
        end
        last_frame[pos] = mag;
        if (!last)
        begin
            if (pos != BIN_IDX_W'(MAX_BINS - 1))
                bin_idx = pos + 1'b1;
            return;
        end
        r.flux = flux_sum;
        flux_sum = '0;
        bin_idx = '0;
        mean = FLUX_W'(hist_sum / RING_LEN);
        if (hops_since < HOPS_SAT)
            hops_since++;
        r.blocked = (hops_since <= refr_hops);
        thr = longint'(mean) * sens_q + EPS_Q28;
        r.fired = ((longint'(r.flux) << SENS_FRAC) > thr) && !r.blocked && gate
                  && (raw >= gate_level);
        if (r.fired)
        begin
            hops_since = '0;
            env_level = ENV_W'(ENV_FULL);
            onset_count++;
            for (int d = 0; d < DIVS; d++)
                if ((onset_count & ((32'd1 << d) - 1)) == 0)
                    div_bits = div_bits ^ DIVS'(1 << d);
        end
        hist_sum = hist_sum - flux_hist[hist_ptr] + r.flux;
        flux_hist[hist_ptr] = r.flux;
        hist_ptr = (hist_ptr == RING_IDX_W'(RING_LEN - 1)) ? '0 : hist_ptr + 1'b1;
        env_level = ENV_W'((longint'(env_level) * decay_q) >> 16);
        r.mean = mean;
        r.env = env_level;
        r.toggles = div_bits;
        r.total = onset_count;
        pending_hops.insert(pending_hops.size(), r);
    endtask

    task automatic push_bin(input logic [MAG_W-1:0] mag, input logic last,
                            input logic [LEVEL_W-1:0] raw, input logic gate);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            bin_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bin_valid <= 1'b1;
        magnitude <= mag;
        last_bin <= last;
        raw_level <= raw;
        material_gate <= gate;
        do @(posedge clk); while (!bin_ready);
        advance_detector(mag, last, raw, gate);
        bins_sent++;
    endtask

    // registers only change with nothing in flight
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        logic [SENS_W-1:0] v;
        bin_valid <= 1'b0;
        while (pending_hops.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        v = data[SENS_W-1:0];
        case (idx)
            REG_SENSITIVITY: sens_q = (v < SENS_MIN) ? SENS_MIN : (v > SENS_MAX) ? SENS_MAX : v;
            REG_REFRACTORY:  refr_hops = data[REFR_W-1:0];
            REG_NOISE_GATE:  gate_level = (v > GATE_MAX) ? GATE_MAX : v;
            REG_ENV_DECAY:   decay_q = data;
            default: ;
        endcase
    endtask

    task automatic send_hop(input int len, input hop_style_t style);
        logic [MAG_W-1:0] mag;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                HOP_QUIET: mag = MAG_W'($urandom_range(0, 4095));
                HOP_BURST: mag = MAG_W'($urandom_range(16384, 65535));
                default:   mag = MAG_W'($urandom_range(0, 65535));
            endcase
            push_bin(mag, i == len - 1, LEVEL_W'($urandom_range(0, 32768)),
                     $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic run_hops(input int quota, input int max_len);
        int target;
        int len;
        int pick;
        hop_style_t style;
        target = bins_sent + quota;
        while (bins_sent < target)
        begin
            if ($urandom_range(0, 15) == 0)
                idle_off = ~idle_off;
            pick = $urandom_range(0, 19);
            len = (pick < 16) ? $urandom_range(1, 8) :
                  (pick < 19) ? $urandom_range(9, 40) : $urandom_range(41, 70);
            if (len > max_len)
                len = max_len;
            pick = $urandom_range(0, 9);
            style = (pick < 5) ? HOP_QUIET : (pick < 8) ? HOP_BURST : HOP_NOISE;
            send_hop(len, style);
        end
        idle_off = 1'b0;
    endtask

    task automatic test_first_onset();
        push_bin(16'hFFFF, 1'b1, 16'd32768, 1'b1);
        push_bin(16'hFFFF, 1'b1, 16'd32768, 1'b1);
        push_bin(16'h0000, 1'b1, 16'd0, 1'b0);
    endtask

    task automatic test_gates();
        write_reg(REG_REFRACTORY, 16'h0000);
        push_bin(16'h0000, 1'b0, 16'h7FFF, 1'b1);
        push_bin(16'hFFFF, 1'b1, 16'd32768, 1'b0);
        write_reg(REG_NOISE_GATE, 16'h7FFF);
        push_bin(16'h5555, 1'b0, 16'd0, 1'b1);
        push_bin(16'h0000, 1'b1, 16'd16383, 1'b1);
        push_bin(16'hAAAA, 1'b0, 16'd0, 1'b0);
        push_bin(16'hFFFF, 1'b1, 16'd16384, 1'b1);
        write_reg(REG_NOISE_GATE, 16'h0000);
        push_bin(16'h0000, 1'b1, 16'h7FFF, 1'b1);
    endtask

    task automatic test_config_limits();
        write_reg(REG_SENSITIVITY, 16'h0000);
        push_bin(16'hFFFF, 1'b1, 16'd32768, 1'b1);
        write_reg(REG_SENSITIVITY, 16'hFFFF);
        push_bin(16'h0000, 1'b0, 16'd0, 1'b1);
        push_bin(16'hFFFF, 1'b1, 16'd32768, 1'b1);
        write_reg(REG_ENV_DECAY, 16'h0000);
        push_bin(16'h0000, 1'b1, 16'd32768, 1'b1);
        push_bin(16'hFFFF, 1'b1, 16'd32768, 1'b1);
        write_reg(REG_ENV_DECAY, 16'hFFFF);
        write_reg(REG_SENSITIVITY, 16'h1000);
        push_bin(16'h0000, 1'b1, 16'd32768, 1'b1);
        push_bin(16'hFFFF, 1'b1, 16'd32768, 1'b1);
        write_reg(REG_REFRACTORY, 16'hFFFF);
        push_bin(16'h0000, 1'b1, 16'd32768, 1'b1);
        push_bin(16'hFFFF, 1'b1, 16'd32768, 1'b1);
    endtask

    // hops past the bin limit; full-scale bins over a zeroed frame, then repeats of the last bin, saturate the flux
    task automatic test_long_hops();
        int len;
        int pairs;
        write_reg(REG_REFRACTORY, 16'h0001);
        repeat (2)
        begin
            len = $urandom_range(MAX_BINS, MAX_BINS + 8);
            for (int i = 0; i < len; i++)
                push_bin(16'h0000, i == len - 1, LEVEL_W'($urandom_range(0, 32768)), 1'b1);
            for (int i = 0; i < MAX_BINS; i++)
                push_bin(16'hFFFF, 1'b0, LEVEL_W'($urandom_range(0, 32768)), 1'b1);
            pairs = $urandom_range(2, 4);
            for (int i = 0; i < pairs; i++)
            begin
                push_bin(16'h0000, 1'b0, LEVEL_W'($urandom_range(0, 32768)), 1'b1);
                push_bin(MAG_W'($urandom_range(60000, 65535)), i == pairs - 1,
                         LEVEL_W'($urandom_range(0, 32768)), 1'b1);
            end
        end
        send_hop($urandom_range(MAX_BINS + 1, MAX_BINS + 8), HOP_NOISE);
    endtask

    task automatic test_onset_stream();
        write_reg(REG_SENSITIVITY, 16'd4096);
        write_reg(REG_REFRACTORY, 16'd1);
        write_reg(REG_NOISE_GATE, 16'd0);
        write_reg(REG_ENV_DECAY, 16'hFFFF);
        run_hops(300, 70);
    endtask

    task automatic test_extreme_settings();
        write_reg(REG_SENSITIVITY, 16'd16384);
        write_reg(REG_REFRACTORY, 16'd255);
        write_reg(REG_NOISE_GATE, 16'd16384);
        write_reg(REG_ENV_DECAY, 16'h0000);
        run_hops(200, 4);
    endtask

    task automatic test_random_settings();
        repeat (4)
        begin
            write_reg(REG_SENSITIVITY, CFG_DATA_W'($urandom_range(0, 65535)));
            write_reg(REG_REFRACTORY, CFG_DATA_W'($urandom_range(0, 65535)));
            write_reg(REG_NOISE_GATE, CFG_DATA_W'($urandom_range(0, 65535)));
            write_reg(REG_ENV_DECAY, CFG_DATA_W'($urandom_range(0, 65535)));
            run_hops(80, 70);
        end
    endtask

    task automatic test_noise_bins();
        write_reg(REG_SENSITIVITY, CFG_DATA_W'(SENS_RESET));
        write_reg(REG_REFRACTORY, CFG_DATA_W'(REFR_RESET));
        write_reg(REG_NOISE_GATE, CFG_DATA_W'(GATE_RESET));
        write_reg(REG_ENV_DECAY, CFG_DATA_W'(DECAY_RESET));
        repeat (150)
            push_bin(MAG_W'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0,
                     LEVEL_W'($urandom_range(0, 32768)), 1'($urandom_range(0, 1)));
        push_bin(MAG_W'($urandom_range(0, 65535)), 1'b1,
                 LEVEL_W'($urandom_range(0, 32768)), 1'b1);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_onset();
        test_gates();
        test_config_limits();
        test_long_hops();
        test_onset_stream();
        test_extreme_settings();
        test_random_settings();
        test_noise_bins();
        bin_valid <= 1'b0;
        while (pending_hops.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = idle_off ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        hop_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_hops.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with no hop pending", $time);
            end
            else
            begin
                want = pending_hops.pop_front();
                check_field("fired", 64'(want.fired), 64'(fired));
                check_field("flux_value", 64'(want.flux), 64'(flux_value));
                check_field("flux_mean", 64'(want.mean), 64'(flux_mean));
                check_field("refractory_blocked", 64'(want.blocked),
                            64'(refractory_blocked));
                check_field("envelope", 64'(want.env), 64'(envelope));
                check_field("division_toggles", 64'(want.toggles), 64'(division_toggles));
                check_field("onset_total", 64'(want.total), 64'(onset_total));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
rtl/sfod_pkg.sv
rtl/sfod_bin_stage.sv
rtl/sfod_flux_ring.sv
rtl/sfod_fire_stage.sv
rtl/spectral_flux_onset_detector.sv
dv/tb_top.sv
